// ----- hdl/nrmc_pkg.sv -----
// Shared types, constants and helper functions of the RMC sentence parser.
package nrmc_pkg;

  localparam int MINUTE_FRAC_DIGITS = 4;
  localparam int VALID_COMMAS       = 12;
  localparam int QUEUE_DEPTH        = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_CHAR   = 2'd0,
    CFG_END_CHAR     = 2'd1,
    CFG_PORT_ENABLED = 2'd2
  } cfg_idx_t;

  localparam logic [7:0] START_CHAR_RST = 8'd36;
  localparam logic [7:0] END_CHAR_RST   = 8'd42;
  localparam logic [7:0] BYTE_COMMA     = 8'd44;
  localparam logic [7:0] BYTE_DOT       = 8'd46;

  // Field numbers (count of commas seen before the field)
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_DATE   = 4'd9;

  localparam logic [7:0] TIME_POS_FIRST = 8'd7;
  localparam logic [7:0] TIME_POS_LAST  = 8'd12;

  localparam int TD_W  = 7;
  localparam int DEG_W = 10;
  localparam logic [11:0] YEAR_BASE = 12'd2000;

  // Minutes scaled to 1e-6 units stay below 1e8 for any fraction digit count up to six.
  localparam int X_W   = 27;
  localparam int Y_W   = 25;   // X / 4
  localparam int Q_W   = 22;   // Y / 15
  localparam int DM_W  = 30;   // degrees times 1e6
  localparam int RECIP_SHIFT = 29;
  localparam logic [25:0] RECIP_15 = 26'd35791394;  // floor(2^29 / 15)
  localparam logic [19:0] MICRO    = 20'd1000000;

  typedef struct packed {
    logic                   valid;
    logic [5:0][TD_W-1:0]   td;       // hh, mm, ss, dd, mo, yy
    logic [7:0]             status;
    logic [7:0]             ns;
    logic [7:0]             ew;
    logic [3:0]             speed;
    logic [DEG_W-1:0]       deg_lat;
    logic [DEG_W-1:0]       deg_lon;
  } rec_t;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  function automatic int min_width(input int f);
    return $clog2(100 * pow10(f));
  endfunction

  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd0;
    if (b inside {[8'd48:8'd57]}) begin
      d = 4'(b - 8'd48);
    end
    return d;
  endfunction

endpackage

// ----- hdl/nrmc_front.sv -----
// Byte parser: config registers, sentence framing and running field accumulators.
module nrmc_front #(
  parameter int MINUTE_FRAC_DIGITS = nrmc_pkg::MINUTE_FRAC_DIGITS,
  parameter int VALID_COMMAS       = nrmc_pkg::VALID_COMMAS,
  parameter int MIN_W              = nrmc_pkg::min_width(nrmc_pkg::MINUTE_FRAC_DIGITS)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [nrmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nrmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            byte_vld_i,
  input  logic [7:0]                      byte_i,
  output logic                            rec_push_o,
  output nrmc_pkg::rec_t                  rec_o,
  output logic [MIN_W-1:0]                min_lat_o,
  output logic [MIN_W-1:0]                min_lon_o
);

  localparam int ACC_W = MIN_W + 4;
  localparam logic [ACC_W-1:0] UNIT = ACC_W'(nrmc_pkg::pow10(MINUTE_FRAC_DIGITS));
  localparam logic [ACC_W-1:0] MAXV = ACC_W'(100 * nrmc_pkg::pow10(MINUTE_FRAC_DIGITS) - 1);
  localparam logic [2:0] FRAC_N = 3'(MINUTE_FRAC_DIGITS);

  logic [7:0] start_r, end_r;
  logic       port_en_r;

  logic                            in_sent_r, in_sent_nxt;
  logic [7:0]                      pos_r, pos_nxt;
  logic [3:0]                      comma_r, comma_nxt;
  logic [3:0]                      cif_r, cif_nxt;
  logic [5:0][nrmc_pkg::TD_W-1:0]  td_r, td_nxt;
  logic [1:0][nrmc_pkg::DEG_W-1:0] deg_r, deg_nxt;
  logic [1:0][MIN_W-1:0]           min_r, min_nxt;
  logic [2:0]                      fdc_r, fdc_nxt;
  logic                            seen_r, seen_nxt;
  logic [3:0][7:0]                 cap_r, cap_nxt;

  // weight of each fraction digit
  logic [ACC_W-1:0] fw [0:7];
  for (genvar i = 0; i < 8; i++) begin : g_fw
    assign fw[i] = (i < MINUTE_FRAC_DIGITS) ?
                   ACC_W'(nrmc_pkg::pow10(MINUTE_FRAC_DIGITS - 1 - i)) : '0;
  end

  // config write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= nrmc_pkg::START_CHAR_RST;
      end_r     <= nrmc_pkg::END_CHAR_RST;
      port_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (nrmc_pkg::cfg_idx_t'(cfg_index))
        nrmc_pkg::CFG_START_CHAR:   start_r   <= cfg_wdata;
        nrmc_pkg::CFG_END_CHAR:     end_r     <= cfg_wdata;
        nrmc_pkg::CFG_PORT_ENABLED: port_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [7:0]       pos_inc;
  logic [3:0]       d;
  logic [2:0]       tk;
  logic [2:0]       dk;
  logic             msel;
  logic [ACC_W-1:0] macc;
  logic [ACC_W-1:0] wide;

  always_comb begin
    in_sent_nxt = in_sent_r;
    pos_nxt     = pos_r;
    comma_nxt   = comma_r;
    cif_nxt     = cif_r;
    td_nxt      = td_r;
    deg_nxt     = deg_r;
    min_nxt     = min_r;
    fdc_nxt     = fdc_r;
    seen_nxt    = seen_r;
    cap_nxt     = cap_r;
    rec_push_o  = 1'b0;

    pos_inc = (pos_r == 8'd255) ? pos_r : pos_r + 8'd1;
    d       = nrmc_pkg::digit_of(byte_i);
    tk      = 3'((pos_inc - nrmc_pkg::TIME_POS_FIRST) >> 1);
    dk      = 3'd3 + {1'b0, cif_r[2:1]};
    msel    = (comma_r == nrmc_pkg::FLD_LON);
    macc    = ACC_W'(min_r[msel]);
    wide    = macc;

    if (byte_vld_i && port_en_r) begin
      if (in_sent_r && byte_i == end_r) begin
        rec_push_o  = 1'b1;
        in_sent_nxt = 1'b0;
      end else if (byte_i == start_r) begin
        in_sent_nxt = 1'b1;
        pos_nxt     = '0;
        comma_nxt   = '0;
        cif_nxt     = '0;
        td_nxt      = '0;
        deg_nxt     = '0;
        min_nxt     = '0;
        fdc_nxt     = '0;
        seen_nxt    = 1'b0;
        cap_nxt     = '0;
      end else if (in_sent_r) begin
        pos_nxt = pos_inc;
        if (pos_inc inside {[nrmc_pkg::TIME_POS_FIRST:nrmc_pkg::TIME_POS_LAST]}) begin
          td_nxt[tk] = 7'(td_r[tk] * 7'd10) + {3'b0, d};
        end
        if (byte_i == nrmc_pkg::BYTE_COMMA) begin
          if (comma_r != 4'd15) comma_nxt = comma_r + 4'd1;
          cif_nxt  = '0;
          fdc_nxt  = '0;
          seen_nxt = 1'b0;
        end else begin
          case (comma_r)
            nrmc_pkg::FLD_STATUS: if (cif_r == 4'd0) cap_nxt[0] = byte_i;
            nrmc_pkg::FLD_NS:     if (cif_r == 4'd0) cap_nxt[1] = byte_i;
            nrmc_pkg::FLD_EW:     if (cif_r == 4'd0) cap_nxt[2] = byte_i;
            nrmc_pkg::FLD_SPEED:  if (cif_r == 4'd0) cap_nxt[3] = {4'b0, d};
            nrmc_pkg::FLD_DATE: begin
              if (cif_r < 4'd6) begin
                td_nxt[dk] = 7'(td_r[dk] * 7'd10) + {3'b0, d};
              end
            end
            nrmc_pkg::FLD_LAT, nrmc_pkg::FLD_LON: begin
              if ((!msel && cif_r < 4'd2) || (msel && cif_r < 4'd3)) begin
                deg_nxt[msel] = 10'(deg_r[msel] * 10'd10) + {6'b0, d};
              end else if (byte_i == nrmc_pkg::BYTE_DOT && !seen_r) begin
                seen_nxt = 1'b1;
              end else begin
                if (!seen_r) begin
                  wide = ACC_W'(macc * ACC_W'(10)) + ACC_W'(ACC_W'(d) * UNIT);
                end else if (fdc_r < FRAC_N) begin
                  wide    = macc + ACC_W'(ACC_W'(d) * fw[fdc_r]);
                  fdc_nxt = fdc_r + 3'd1;
                end
                min_nxt[msel] = (wide > MAXV) ? MIN_W'(MAXV) : wide[MIN_W-1:0];
              end
            end
            default: ;
          endcase
          if (cif_r != 4'd15) cif_nxt = cif_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sent_r <= 1'b0;
      pos_r     <= '0;
      comma_r   <= '0;
      cif_r     <= '0;
      td_r      <= '0;
      deg_r     <= '0;
      min_r     <= '0;
      fdc_r     <= '0;
      seen_r    <= 1'b0;
      cap_r     <= '0;
    end else begin
      in_sent_r <= in_sent_nxt;
      pos_r     <= pos_nxt;
      comma_r   <= comma_nxt;
      cif_r     <= cif_nxt;
      td_r      <= td_nxt;
      deg_r     <= deg_nxt;
      min_r     <= min_nxt;
      fdc_r     <= fdc_nxt;
      seen_r    <= seen_nxt;
      cap_r     <= cap_nxt;
    end
  end

  always_comb begin
    rec_o.valid   = (comma_r >= 4'(VALID_COMMAS));
    rec_o.td      = td_r;
    rec_o.status  = cap_r[0];
    rec_o.ns      = cap_r[1];
    rec_o.ew      = cap_r[2];
    rec_o.speed   = cap_r[3][3:0];
    rec_o.deg_lat = deg_r[0];
    rec_o.deg_lon = deg_r[1];
  end
  assign min_lat_o = min_r[0];
  assign min_lon_o = min_r[1];

  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    rec_push_o |=> !in_sent_r) else $error("sentence still open after record");
  a_min_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ACC_W'(min_r[0]) <= MAXV) && (ACC_W'(min_r[1]) <= MAXV))
    else $error("minute accumulator above saturation");

endmodule

// ----- hdl/nrmc_queue.sv -----
// Small synchronous FIFO between parser and conversion pipeline.
module nrmc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = nrmc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW-1:0]    wr_r, rd_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == CW'(DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_r] <= data_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= (wr_r == LAST) ? '0 : wr_r + AW'(1);
      if (do_pop)  rd_r <= (rd_r == LAST) ? '0 : rd_r + AW'(1);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count overflow");
  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (cnt_r == $past(cnt_r) - CW'(1)))
    else $error("queue count did not drop on pop");

endmodule

// ----- hdl/nrmc_back.sv -----
// Conversion pipeline: minutes to micro-degrees, output register and zeroing.
module nrmc_back #(
  parameter int MINUTE_FRAC_DIGITS = nrmc_pkg::MINUTE_FRAC_DIGITS,
  parameter int MIN_W              = nrmc_pkg::min_width(nrmc_pkg::MINUTE_FRAC_DIGITS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  nrmc_pkg::rec_t       rec_i,
  input  logic [MIN_W-1:0]     min_lat_i,
  input  logic [MIN_W-1:0]     min_lon_i,
  output logic                 rdy_o,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_valid_res,
  output logic [6:0]           out_utc_hour,
  output logic [6:0]           out_utc_minute,
  output logic [6:0]           out_utc_second,
  output logic [6:0]           out_day_of_month,
  output logic [6:0]           out_month_number,
  output logic [11:0]          out_full_year,
  output logic [7:0]           out_fix_status,
  output logic [26:0]          out_latitude_micro_deg,
  output logic [29:0]          out_longitude_micro_deg,
  output logic [15:0]          out_hemispheres,
  output logic [3:0]           out_speed_digit
);

  localparam int X_W  = nrmc_pkg::X_W;
  localparam int Y_W  = nrmc_pkg::Y_W;
  localparam int Q_W  = nrmc_pkg::Q_W;
  localparam int DM_W = nrmc_pkg::DM_W;
  localparam int P_W  = Y_W + 26;
  localparam logic [X_W-1:0] SCALE = X_W'(nrmc_pkg::pow10(6 - MINUTE_FRAC_DIGITS));

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3  = !v3_r || out_pop;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;
  assign rdy_o = rdy1;
  assign out_empty = !v3_r;

  // stage 1: scale minutes to 1e-6 minute units, degrees to micro-degrees
  nrmc_pkg::rec_t           rec1_r, rec2_r;
  logic [1:0][X_W-1:0]      x1_r;
  logic [1:0][DM_W-1:0]     dm1_r, dm2_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      rec1_r   <= rec_i;
      x1_r[0]  <= X_W'(X_W'(min_lat_i) * SCALE);
      x1_r[1]  <= X_W'(X_W'(min_lon_i) * SCALE);
      dm1_r[0] <= DM_W'(DM_W'(rec_i.deg_lat) * DM_W'(nrmc_pkg::MICRO));
      dm1_r[1] <= DM_W'(DM_W'(rec_i.deg_lon) * DM_W'(nrmc_pkg::MICRO));
    end
  end

  // stage 2: y = x/4, estimate y/15 by reciprocal multiply (low by at most one)
  logic [1:0][Y_W-1:0] y2_r;
  logic [1:0][Q_W-1:0] q2_r;
  logic [1:0][Y_W-1:0] y1;
  logic [1:0][P_W-1:0] p1;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      y1[i] = x1_r[i][X_W-1:2];
      p1[i] = P_W'(y1[i]) * P_W'(nrmc_pkg::RECIP_15);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      rec2_r <= rec1_r;
      dm2_r  <= dm1_r;
      for (int i = 0; i < 2; i++) begin
        y2_r[i] <= y1[i];
        q2_r[i] <= p1[i][nrmc_pkg::RECIP_SHIFT +: Q_W];
      end
    end
  end

  // stage 3: correct quotient, add degrees, zero weak-signal records
  logic [1:0][Y_W-1:0]    rem2;
  logic [1:0][Q_W-1:0]    q2;
  logic [1:0][DM_W:0]     sum2;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rem2[i] = y2_r[i] - Y_W'({q2_r[i], 4'b0} - {4'b0, q2_r[i]});
      q2[i]   = q2_r[i] + Q_W'(rem2[i] >= Y_W'(15));
      sum2[i] = (DM_W + 1)'(dm2_r[i]) + (DM_W + 1)'(q2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      out_valid_res           <= rec2_r.valid;
      out_utc_hour            <= rec2_r.valid ? rec2_r.td[0] : '0;
      out_utc_minute          <= rec2_r.valid ? rec2_r.td[1] : '0;
      out_utc_second          <= rec2_r.valid ? rec2_r.td[2] : '0;
      out_day_of_month        <= rec2_r.valid ? rec2_r.td[3] : '0;
      out_month_number        <= rec2_r.valid ? rec2_r.td[4] : '0;
      out_full_year           <= rec2_r.valid ?
                                 12'(rec2_r.td[5]) + nrmc_pkg::YEAR_BASE : '0;
      out_fix_status          <= rec2_r.valid ? rec2_r.status : '0;
      out_latitude_micro_deg  <= rec2_r.valid ? sum2[0][26:0] : '0;
      out_longitude_micro_deg <= rec2_r.valid ? sum2[1][29:0] : '0;
      out_hemispheres         <= rec2_r.valid ? {rec2_r.ns, rec2_r.ew} : '0;
      out_speed_digit         <= rec2_r.valid ? rec2_r.speed : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= vld_i;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  a_weak_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_valid_res) |-> (out_latitude_micro_deg == '0 &&
                                  out_fix_status == '0 && out_full_year == '0))
    else $error("weak-signal record carries data");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rem2[0] < Y_W'(30) && rem2[1] < Y_W'(30)))
    else $error("reciprocal estimate off by more than one");

endmodule

// ----- hdl/nmea_rmc_sentence_parser_top.sv -----
// Top level of the RMC sentence parser: parser, record queue and conversion pipeline.
// Throughput: one input byte per cycle while in_full is low; one result transaction per cycle
//   when popped steadily. A record is written to the queue at the edge that accepts its end
//   byte and passes through the three pipeline stages to the result ports (out_empty low).
// in_full rises only when the record queue is full and the pipeline is stalled by out_pop.
// Reset (rst_n low, synchronous): parser, queue and pipeline cleared; '$', '*', port on.
module nmea_rmc_sentence_parser_top #(
  parameter int MINUTE_FRAC_DIGITS = nrmc_pkg::MINUTE_FRAC_DIGITS,
  parameter int VALID_COMMAS       = nrmc_pkg::VALID_COMMAS,
  parameter int QUEUE_DEPTH        = nrmc_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [nrmc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nrmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // byte input, queue style
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [7:0]                      in_rx_byte,
  // records out, queue style
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic                            out_valid_res,
  output logic [6:0]                      out_utc_hour,
  output logic [6:0]                      out_utc_minute,
  output logic [6:0]                      out_utc_second,
  output logic [6:0]                      out_day_of_month,
  output logic [6:0]                      out_month_number,
  output logic [11:0]                     out_full_year,
  output logic [7:0]                      out_fix_status,
  output logic [26:0]                     out_latitude_micro_deg,
  output logic [29:0]                     out_longitude_micro_deg,
  output logic [15:0]                     out_hemispheres,
  output logic [3:0]                      out_speed_digit
);

  // minute accumulator width follows the fraction digit count
  localparam int MIN_W = nrmc_pkg::min_width(MINUTE_FRAC_DIGITS);
  localparam int REC_W = $bits(nrmc_pkg::rec_t) + 2 * MIN_W;

  logic               byte_vld;
  logic               rec_push;
  nrmc_pkg::rec_t     rec_f, rec_b;
  logic [MIN_W-1:0]   min_lat_f, min_lon_f, min_lat_b, min_lon_b;
  logic [REC_W-1:0]   q_wdata, q_rdata;
  logic               q_empty, back_rdy;

  // a byte transaction is taken whenever the queue has room, so an end byte
  // always finds a slot for its record
  assign byte_vld = in_push && !in_full;

  nrmc_front #(
    .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS),
    .VALID_COMMAS       (VALID_COMMAS),
    .MIN_W              (MIN_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_vld_i (byte_vld),
    .byte_i     (in_rx_byte),
    .rec_push_o (rec_push),
    .rec_o      (rec_f),
    .min_lat_o  (min_lat_f),
    .min_lon_o  (min_lon_f)
  );

  assign q_wdata = {rec_f, min_lat_f, min_lon_f};

  nrmc_queue #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (rec_push),
    .data_i  (q_wdata),
    .full_o  (in_full),
    .pop_i   (back_rdy),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  assign {rec_b, min_lat_b, min_lon_b} = q_rdata;

  // three-stage elastic pipeline; its last stage is the output register
  nrmc_back #(
    .MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS),
    .MIN_W              (MIN_W)
  ) u_back (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .vld_i                   (!q_empty),
    .rec_i                   (rec_b),
    .min_lat_i               (min_lat_b),
    .min_lon_i               (min_lon_b),
    .rdy_o                   (back_rdy),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_valid_res           (out_valid_res),
    .out_utc_hour            (out_utc_hour),
    .out_utc_minute          (out_utc_minute),
    .out_utc_second          (out_utc_second),
    .out_day_of_month        (out_day_of_month),
    .out_month_number        (out_month_number),
    .out_full_year           (out_full_year),
    .out_fix_status          (out_fix_status),
    .out_latitude_micro_deg  (out_latitude_micro_deg),
    .out_longitude_micro_deg (out_longitude_micro_deg),
    .out_hemispheres         (out_hemispheres),
    .out_speed_digit         (out_speed_digit)
  );

endmodule

// ----- test/nmea_rmc_sentence_parser_top_test.sv -----
// Self-checking testbench for the NMEA RMC sentence parser top level.
module nmea_rmc_sentence_parser_top_test;

  // Minute fixed point: FRAC fraction digits, one minute = MIN_UNIT counts.
  localparam int FRAC = (nrmc_pkg::MINUTE_FRAC_DIGITS > 6) ? 6 : nrmc_pkg::MINUTE_FRAC_DIGITS;
  localparam longint unsigned MIN_UNIT = 64'd10 ** FRAC;
  localparam longint unsigned MIN_MAX  = 100 * MIN_UNIT - 1;
  localparam longint unsigned MICRO_DEG = 64'd1000000;

  // Index past the register list: the write must be dropped.
  localparam logic [nrmc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam logic [7:0] CH_ZERO = "0";

  typedef struct {
    logic        valid;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [11:0] year;
    logic [7:0]  status;
    logic [26:0] lat;
    logic [29:0] lon;
    logic [15:0] hemi;
    logic [3:0]  speed;
  } rmc_rec_t;

  function automatic logic [3:0] ascii_val(logic [7:0] b);
    return (b >= "0" && b <= "9") ? 4'(b - CH_ZERO) : 4'd0;
  endfunction

  // Tracks the parser state byte by byte and holds the records it must emit,
  // oldest first.
  class rmc_record_tracker;
    logic [7:0]      start_b, end_b;
    logic            port_on;
    bit              in_sent;
    logic [7:0]      pos;
    logic [3:0]      commas, fchar;
    logic [7:0]      tdd[6];    // hh mm ss dd mo yy
    logic [15:0]     deg[2];    // lat, lon degrees
    longint unsigned mins[2];   // minutes in 1/MIN_UNIT steps
    int              frac_cnt;
    bit              dot_seen;
    logic [7:0]      caps[4];   // status, N/S, E/W, speed digit
    rmc_rec_t        pending_records[$];
    int              mismatches, records_made, records_checked, weak_seen;

    function new();
      start_b = nrmc_pkg::START_CHAR_RST;
      end_b   = nrmc_pkg::END_CHAR_RST;
      port_on = 1'b1;
      in_sent = 1'b0;
      mismatches = 0;
      records_made = 0;
      records_checked = 0;
      weak_seen = 0;
      clear();
    endfunction

    function void clear();
      pos = '0;
      commas = '0;
      fchar = '0;
      foreach (tdd[i]) tdd[i] = '0;
      foreach (deg[i]) deg[i] = '0;
      foreach (mins[i]) mins[i] = 0;
      frac_cnt = 0;
      dot_seen = 1'b0;
      foreach (caps[i]) caps[i] = '0;
    endfunction

    function void set_reg(logic [nrmc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        nrmc_pkg::CFG_START_CHAR:   start_b = v;
        nrmc_pkg::CFG_END_CHAR:     end_b = v;
        nrmc_pkg::CFG_PORT_ENABLED: port_on = v[0];
        default: ;
      endcase
    endfunction

    function void minute_byte(int w, logic [7:0] b);
      longint unsigned acc;
      longint unsigned d;
      acc = mins[w];
      if (b == nrmc_pkg::BYTE_DOT && !dot_seen) begin
        dot_seen = 1'b1;
        return;
      end
      d = longint'(ascii_val(b));
      if (!dot_seen) begin
        acc = acc * 10 + d * MIN_UNIT;
      end else if (frac_cnt < FRAC) begin
        acc = acc + d * (64'd10 ** (FRAC - 1 - frac_cnt));
        frac_cnt++;
      end
      mins[w] = (acc > MIN_MAX) ? MIN_MAX : acc;
    endfunction

    function void data_byte(logic [7:0] b);
      logic [3:0] c;
      logic [3:0] d;
      int k;
      c = fchar;
      d = ascii_val(b);
      if (pos != 8'd255) pos++;
      if (pos >= nrmc_pkg::TIME_POS_FIRST && pos <= nrmc_pkg::TIME_POS_LAST) begin
        k = int'((pos - nrmc_pkg::TIME_POS_FIRST) >> 1);
        tdd[k] = tdd[k] * 8'd10 + 8'(d);
      end
      if (b == nrmc_pkg::BYTE_COMMA) begin
        if (commas != 4'd15) commas++;
        fchar = '0;
        frac_cnt = 0;
        dot_seen = 1'b0;
        return;
      end
      case (commas)
        nrmc_pkg::FLD_STATUS: if (c == 4'd0) caps[0] = b;
        nrmc_pkg::FLD_LAT: begin
          if (c < 4'd2) deg[0] = deg[0] * 16'd10 + 16'(d);
          else minute_byte(0, b);
        end
        nrmc_pkg::FLD_NS:     if (c == 4'd0) caps[1] = b;
        nrmc_pkg::FLD_LON: begin
          if (c < 4'd3) deg[1] = deg[1] * 16'd10 + 16'(d);
          else minute_byte(1, b);
        end
        nrmc_pkg::FLD_EW:     if (c == 4'd0) caps[2] = b;
        nrmc_pkg::FLD_SPEED:  if (c == 4'd0) caps[3] = 8'(d);
        nrmc_pkg::FLD_DATE: begin
          if (c < 4'd6) begin
            k = 3 + int'(c >> 1);
            tdd[k] = tdd[k] * 8'd10 + 8'(d);
          end
        end
        default: ;
      endcase
      if (c != 4'd15) fchar = c + 4'd1;
    endfunction

    function longint unsigned micro_deg(int w);
      return longint'(deg[w]) * MICRO_DEG + mins[w] * MICRO_DEG / (60 * MIN_UNIT);
    endfunction

    // One accepted byte; an end byte inside a sentence yields a record.
    function void take_byte(logic [7:0] b);
      rmc_rec_t r;
      longint unsigned v;
      if (!port_on) return;
      if (in_sent && b == end_b) begin
        r = '{default: '0};
        in_sent = 1'b0;
        if (int'(commas) >= nrmc_pkg::VALID_COMMAS) begin
          r.valid  = 1'b1;
          r.hour   = tdd[0][6:0];
          r.minute = tdd[1][6:0];
          r.second = tdd[2][6:0];
          r.day    = tdd[3][6:0];
          r.month  = tdd[4][6:0];
          r.year   = 12'(tdd[5]) + nrmc_pkg::YEAR_BASE;
          r.status = caps[0];
          v = micro_deg(0);
          r.lat = v[26:0];
          v = micro_deg(1);
          r.lon = v[29:0];
          r.hemi  = {caps[1], caps[2]};
          r.speed = caps[3][3:0];
        end
        pending_records.push_back(r);
        records_made++;
        return;
      end
      if (b == start_b) begin
        clear();
        in_sent = 1'b1;
        return;
      end
      if (in_sent) data_byte(b);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        flag_mismatch($sformatf("record %0d %s got %0h want %0h",
                                records_checked, name, got, want));
    endtask

    task check_record(rmc_rec_t got);
      rmc_rec_t w;
      if (pending_records.size() == 0) begin
        flag_mismatch("record popped with nothing outstanding");
        return;
      end
      w = pending_records.pop_front();
      if (!w.valid) weak_seen++;
      cmp("valid_res", 32'(got.valid), 32'(w.valid));
      cmp("utc_hour", 32'(got.hour), 32'(w.hour));
      cmp("utc_minute", 32'(got.minute), 32'(w.minute));
      cmp("utc_second", 32'(got.second), 32'(w.second));
      cmp("day_of_month", 32'(got.day), 32'(w.day));
      cmp("month_number", 32'(got.month), 32'(w.month));
      cmp("full_year", 32'(got.year), 32'(w.year));
      cmp("fix_status", 32'(got.status), 32'(w.status));
      cmp("latitude", 32'(got.lat), 32'(w.lat));
      cmp("longitude", 32'(got.lon), 32'(w.lon));
      cmp("hemispheres", 32'(got.hemi), 32'(w.hemi));
      cmp("speed_digit", 32'(got.speed), 32'(w.speed));
      records_checked++;
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [nrmc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nrmc_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                            in_push;
  logic                            in_full;
  logic [7:0]                      in_rx_byte;
  logic                            out_empty;
  logic                            out_pop;
  logic                            out_valid_res;
  logic [6:0]                      out_utc_hour, out_utc_minute, out_utc_second;
  logic [6:0]                      out_day_of_month, out_month_number;
  logic [11:0]                     out_full_year;
  logic [7:0]                      out_fix_status;
  logic [26:0]                     out_latitude_micro_deg;
  logic [29:0]                     out_longitude_micro_deg;
  logic [15:0]                     out_hemispheres;
  logic [3:0]                      out_speed_digit;

  nmea_rmc_sentence_parser_top uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_push                 (in_push),
    .in_full                 (in_full),
    .in_rx_byte              (in_rx_byte),
    .out_empty               (out_empty),
    .out_pop                 (out_pop),
    .out_valid_res           (out_valid_res),
    .out_utc_hour            (out_utc_hour),
    .out_utc_minute          (out_utc_minute),
    .out_utc_second          (out_utc_second),
    .out_day_of_month        (out_day_of_month),
    .out_month_number        (out_month_number),
    .out_full_year           (out_full_year),
    .out_fix_status          (out_fix_status),
    .out_latitude_micro_deg  (out_latitude_micro_deg),
    .out_longitude_micro_deg (out_longitude_micro_deg),
    .out_hemispheres         (out_hemispheres),
    .out_speed_digit         (out_speed_digit)
  );

  rmc_record_tracker tracker;

  // Generator view of the framing bytes, kept in step with register writes.
  logic [7:0] lead_char = nrmc_pkg::START_CHAR_RST;
  logic [7:0] tail_char = nrmc_pkg::END_CHAR_RST;
  logic [7:0] line_q[$];
  bit         idle_on = 1'b1;  // cleared for the last part of the run
  int         sender_odds = 0; // 0: no sender gaps for the current line
  int         bytes_accepted = 0;
  int         cfg_writes = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. Content bytes are printable and never collide with the
  // framing bytes, so well-formed lines reach every field; noise and cut-off
  // lines come from separate branches.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == lead_char || c == tail_char);
    return c;
  endfunction

  // Nines and zeros come often so that saturation and empty values show up.
  function automatic logic [7:0] pick_digit();
    case ($urandom_range(0, 7))
      0, 1:    return "9";
      2:       return "0";
      default: return CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void put_digits(int n);
    repeat (n) line_q.push_back(pick_digit());
  endfunction

  function automatic void put_text(int n);
    repeat (n) line_q.push_back(pick_text());
  endfunction

  function automatic void put_flag(logic [7:0] a, logic [7:0] b);
    case ($urandom_range(0, 5))
      0:       ;
      1:       put_text($urandom_range(1, 2));
      2:       line_q.push_back(b);
      default: line_q.push_back(a);
    endcase
  endfunction

  // ddmm.mmmm / dddmm.mmmm with assorted malformations
  function automatic void put_coord(int deg_digits);
    case ($urandom_range(0, 7))
      0: ;
      1: put_text($urandom_range(1, 12));
      2: put_digits(deg_digits + 2 + $urandom_range(0, 3));  // no point, often saturates
      3: begin
        put_digits($urandom_range(0, deg_digits + 1));
        line_q.push_back(nrmc_pkg::BYTE_DOT);
        put_digits($urandom_range(0, 5));
      end
      default: begin
        put_digits(deg_digits + 2);
        line_q.push_back(nrmc_pkg::BYTE_DOT);
        put_digits($urandom_range(0, 7));
        if ($urandom_range(0, 5) == 0) begin
          line_q.push_back(nrmc_pkg::BYTE_DOT);
          put_digits($urandom_range(0, 2));
        end
      end
    endcase
  endfunction

  function automatic void put_field(int f);
    case (f)
      1: begin
        if ($urandom_range(0, 4) == 0) put_text($urandom_range(0, 9));
        else begin
          put_digits(6);
          if ($urandom_range(0, 1) == 1) begin
            line_q.push_back(nrmc_pkg::BYTE_DOT);
            put_digits(2);
          end
        end
      end
      2:  put_flag("A", "V");
      3:  put_coord(2);
      4:  put_flag("N", "S");
      5:  put_coord(3);
      6, 11: put_flag("E", "W");
      7: begin
        if ($urandom_range(0, 4) == 0) put_text($urandom_range(0, 3));
        else begin
          put_digits($urandom_range(1, 3));
          line_q.push_back(nrmc_pkg::BYTE_DOT);
          put_digits(1);
        end
      end
      8:  put_digits($urandom_range(0, 5));
      9: begin
        if ($urandom_range(0, 4) == 0) put_text($urandom_range(0, 8));
        else put_digits(6 + $urandom_range(0, 2));
      end
      10: put_digits($urandom_range(0, 4));
      12: put_flag("A", "D");
      default: put_text($urandom_range(0, 3));
    endcase
  endfunction

  // One RMC-like line; usually twelve fields, sometimes fewer or more.
  function automatic void put_sentence(bit closed);
    string talker;
    int nf;
    talker = "GPRMC";
    line_q.push_back(lead_char);
    // an odd talker field moves commas into the time positions
    if ($urandom_range(0, 4) == 0) put_text($urandom_range(0, 7));
    else for (int i = 0; i < talker.len(); i++) line_q.push_back(talker[i]);
    case ($urandom_range(0, 7))
      0:       nf = $urandom_range(0, 11);
      1:       nf = $urandom_range(13, 18);
      default: nf = 12;
    endcase
    for (int f = 1; f <= nf; f++) begin
      line_q.push_back(nrmc_pkg::BYTE_COMMA);
      put_field(f);
    end
    if (closed) line_q.push_back(tail_char);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Presents one byte and holds it until the input side takes the transaction.
  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    if (idle_on && sender_odds != 0 && $urandom_range(0, 3 * sender_odds) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_full);
    tracker.take_byte(b);
    bytes_accepted++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Registers only change with the parser idle: input off, nothing outstanding,
  // and the pipeline latency waited out.
  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic [nrmc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    if (idx == nrmc_pkg::CFG_START_CHAR) lead_char = val;
    else if (idx == nrmc_pkg::CFG_END_CHAR) tail_char = val;
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic until both the byte and the record counts of the phase
  // are reached. Mostly full sentences, plus noise, cut-off lines, stray end
  // bytes and minimal sentences that make records cheaply.
  task automatic run_traffic(int min_bytes, int min_records);
    int bytes0;
    int rec0;
    int cut;
    bytes0 = bytes_accepted;
    rec0 = tracker.records_made;
    while (bytes_accepted - bytes0 < min_bytes ||
           tracker.records_made - rec0 < min_records) begin
      sender_odds = $urandom_range(0, 3);
      case ($urandom_range(0, 11))
        0: repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom_range(0, 255)));
        1: begin
          put_sentence(1'b0);
          cut = $urandom_range(1, line_q.size());
          while (line_q.size() > cut) void'(line_q.pop_back());
        end
        2: line_q.push_back(tail_char);
        3: begin
          line_q.push_back(lead_char);
          repeat ($urandom_range(nrmc_pkg::VALID_COMMAS, 15)) begin
            line_q.push_back(nrmc_pkg::BYTE_COMMA);
            put_text($urandom_range(0, 2));
          end
          line_q.push_back(tail_char);
        end
        default: put_sentence(1'b1);
      endcase
      send_line();
    end
  endtask

  // Result side: pops with random stall bursts, checks every popped record.
  initial begin
    rmc_rec_t got;
    int stall_left;
    int odds;
    int mode_left;
    stall_left = 0;
    odds = 0;
    mode_left = 0;
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        odds = $urandom_range(0, 3);  // zero gives a stretch without stalls
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (!idle_on) stall_left = 0;
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (idle_on && odds != 0 && $urandom_range(0, 4 * odds) == 0) begin
        stall_left = $urandom_range(0, 12);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
      @(posedge clk);
      if (out_pop && !out_empty) begin
        got.valid  = out_valid_res;
        got.hour   = out_utc_hour;
        got.minute = out_utc_minute;
        got.second = out_utc_second;
        got.day    = out_day_of_month;
        got.month  = out_month_number;
        got.year   = out_full_year;
        got.status = out_fix_status;
        got.lat    = out_latitude_micro_deg;
        got.lon    = out_longitude_micro_deg;
        got.hemi   = out_hemispheres;
        got.speed  = out_speed_digit;
        tracker.check_record(got);
      end
    end
  end

  // Main sequence
  initial begin
    int cut;
    tracker = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_push = 1'b0;
    in_rx_byte = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: end byte outside a sentence, weak record, restart inside a
    // sentence followed by a valid all-empty record, all-zero/all-one bytes.
    send_text("*");
    send_text("$,*");
    send_text("$,,$,,,,,,,,,,,,*");
    send_byte(8'h00);
    send_byte(8'hFF);

    run_traffic(400, 4);

    // Framing bytes at the extremes, then swapped.
    wait_idle();
    cfg_write(nrmc_pkg::CFG_START_CHAR, 8'h00);
    cfg_write(nrmc_pkg::CFG_END_CHAR, 8'hFF);
    run_traffic(120, 1);
    wait_idle();
    cfg_write(nrmc_pkg::CFG_START_CHAR, 8'hFF);
    cfg_write(nrmc_pkg::CFG_END_CHAR, 8'h00);
    run_traffic(120, 1);

    // Same byte opens and closes a sentence.
    wait_idle();
    cfg_write(nrmc_pkg::CFG_START_CHAR, "#");
    cfg_write(nrmc_pkg::CFG_END_CHAR, "#");
    run_traffic(120, 1);

    // Out-of-range index is dropped; back to the usual framing.
    wait_idle();
    cfg_write(CFG_IDX_SPARE, 8'hA5);
    cfg_write(nrmc_pkg::CFG_START_CHAR, nrmc_pkg::START_CHAR_RST);
    cfg_write(nrmc_pkg::CFG_END_CHAR, nrmc_pkg::END_CHAR_RST);

    // Port off in the middle of a sentence: bytes are dropped and the partial
    // sentence survives until the port comes back.
    sender_odds = 1;
    put_sentence(1'b1);
    cut = $urandom_range(1, line_q.size() - 1);
    for (int i = 0; i < cut; i++) send_byte(line_q[i]);
    wait_idle();
    cfg_write(nrmc_pkg::CFG_PORT_ENABLED, 8'hFE);  // only bit 0 counts
    send_byte(lead_char);
    repeat (30) send_byte(8'($urandom_range(0, 255)));
    send_byte(tail_char);
    wait_idle();
    cfg_write(nrmc_pkg::CFG_PORT_ENABLED, 8'h01);
    for (int i = cut; i < line_q.size(); i++) send_byte(line_q[i]);
    line_q.delete();

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    run_traffic(330, 4);

    wait_idle();
    if (tracker.pending_records.size() != 0)
      tracker.flag_mismatch("records still outstanding at end of run");
    $display("Covered %0d accepted bytes and %0d register writes, incl. extreme framing bytes.",
             bytes_accepted, cfg_writes);
    $display("Checked %0d records (%0d weak signal), %0d mismatches.",
             tracker.records_checked, tracker.weak_seen, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/nrmc_pkg.sv
hdl/nrmc_front.sv
hdl/nrmc_queue.sv
hdl/nrmc_back.sv
hdl/nmea_rmc_sentence_parser_top.sv
test/nmea_rmc_sentence_parser_top_test.sv
